// ===== rtl/core/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ARENA_BITS_DEF = 20;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  // Allocation rules
  localparam int unsigned ALIGN_MASK = 32'h1F;  // grain is 32 bytes
  localparam int unsigned SPLIT_MIN  = 32'h21;  // min remainder to split
  localparam int unsigned HDR_BYTES  = 32'h10;  // grant = start + header

  // Result codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_NO_FIT  = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SH,
    S_A_SHWR,
    S_A_WRU,
    S_F_RD,
    S_F_CHK,
    S_F_LRD,
    S_F_LCHK,
    S_F_URD,
    S_F_UCHK,
    S_RM,
    S_RM_WR,
    S_F_WR,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,      // write block 0 = whole arena, count = 1
    OP_LOAD,      // take the item
    OP_RD,        // read table[idx]
    OP_RD_M1,     // read table[idx-1]
    OP_RD_P1,     // read table[idx+1]
    OP_RD_PM1,    // read table[ptr-1]
    OP_RD_PP1,    // read table[ptr+1]
    OP_CHK,       // latch block just read, ptr = count
    OP_NEXT,      // step search index
    OP_WR_SHUP,   // table[ptr] = read data, ptr--
    OP_WR_REM,    // insert split remainder at idx+1, count++
    OP_WR_USED,   // mark block idx used, post grant
    OP_MERGE_LO,  // fold lower neighbor into current block
    OP_MERGE_HI,  // fold upper neighbor into current block
    OP_WR_SHDN,   // table[ptr] = read data, ptr++
    OP_CNT_DEC,   // count--
    OP_WR_FREE,   // write merged free block at idx
    OP_PUSH       // move result into output register
  } op_e;

  typedef struct packed {
    op_e  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic init_pend;   // table needs its block 0 written
    logic is_free;     // action of offered item
    logic off_null;    // offered release offset is zero
    logic fit;         // block read is free and long enough
    logic split;       // block read would be split
    logic last_alloc;  // alloc search is on block 0 (the last one tried)
    logic match;       // block read carries the released offset
    logic last_free;   // free search is on the last block
    logic idx_nz;      // a lower neighbor exists
    logic has_upper;   // an upper neighbor exists
    logic nbr_free;    // block read is free
    logic sh_more;     // insertion shift not finished
    logic rm_more;     // removal shift not finished
    logic out_busy;    // output register holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffha_req_if.sv =====
`default_nettype none

interface ffha_req_if #(
  parameter int unsigned ARENA_BITS = ffha_pkg::ARENA_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [ARENA_BITS:0]   request_bytes;
  logic [ARENA_BITS-1:0] release_offset;

  modport source (output valid, action, request_bytes, release_offset, input ready);
  modport sink   (input valid, action, request_bytes, release_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffha_rsp_if.sv =====
`default_nettype none

interface ffha_rsp_if #(
  parameter int unsigned ARENA_BITS = ffha_pkg::ARENA_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [ARENA_BITS-1:0] granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
`default_nettype none

module ffha_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t     cmd_o
);

  ffha_pkg::state_e state_q, state_d;
  logic             rm_upper_q, rm_upper_d;  // removal belongs to upper merge

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffha_pkg::S_IDLE;
      rm_upper_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rm_upper_q <= rm_upper_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    rm_upper_d = rm_upper_q;
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (!sts_i.init_pend && in_valid_i) begin
          if (!sts_i.is_free) begin
            state_d = ffha_pkg::S_A_RD;
          end else if (sts_i.off_null) begin
            state_d = ffha_pkg::S_DONE;
          end else begin
            state_d = ffha_pkg::S_F_RD;
          end
        end
      end
      ffha_pkg::S_A_RD: state_d = ffha_pkg::S_A_CHK;
      ffha_pkg::S_A_CHK: begin
        if (sts_i.fit) begin
          state_d = sts_i.split ? ffha_pkg::S_A_SH : ffha_pkg::S_A_WRU;
        end else if (sts_i.last_alloc) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = ffha_pkg::S_A_RD;
        end
      end
      ffha_pkg::S_A_SH: state_d = sts_i.sh_more ? ffha_pkg::S_A_SHWR : ffha_pkg::S_A_WRU;
      ffha_pkg::S_A_SHWR: state_d = ffha_pkg::S_A_SH;
      ffha_pkg::S_A_WRU: state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_F_RD: state_d = ffha_pkg::S_F_CHK;
      ffha_pkg::S_F_CHK: begin
        if (sts_i.match) begin
          state_d = sts_i.idx_nz ? ffha_pkg::S_F_LRD : ffha_pkg::S_F_URD;
        end else if (sts_i.last_free) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = ffha_pkg::S_F_RD;
        end
      end
      ffha_pkg::S_F_LRD: state_d = ffha_pkg::S_F_LCHK;
      ffha_pkg::S_F_LCHK: begin
        if (sts_i.nbr_free) begin
          state_d    = ffha_pkg::S_RM;
          rm_upper_d = 1'b0;
        end else begin
          state_d = ffha_pkg::S_F_URD;
        end
      end
      ffha_pkg::S_F_URD: state_d = sts_i.has_upper ? ffha_pkg::S_F_UCHK : ffha_pkg::S_F_WR;
      ffha_pkg::S_F_UCHK: begin
        if (sts_i.nbr_free) begin
          state_d    = ffha_pkg::S_RM;
          rm_upper_d = 1'b1;
        end else begin
          state_d = ffha_pkg::S_F_WR;
        end
      end
      ffha_pkg::S_RM: begin
        if (sts_i.rm_more) begin
          state_d = ffha_pkg::S_RM_WR;
        end else begin
          state_d = rm_upper_q ? ffha_pkg::S_F_WR : ffha_pkg::S_F_URD;
        end
      end
      ffha_pkg::S_RM_WR: state_d = ffha_pkg::S_RM;
      ffha_pkg::S_F_WR: state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ffha_pkg::S_IDLE;
        end
      end
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op       = ffha_pkg::OP_NONE;
    cmd_o.in_ready = 1'b0;
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (sts_i.init_pend) begin
          cmd_o.op = ffha_pkg::OP_INIT;
        end else begin
          cmd_o.in_ready = 1'b1;
          if (in_valid_i) begin
            cmd_o.op = ffha_pkg::OP_LOAD;
          end
        end
      end
      ffha_pkg::S_A_RD: cmd_o.op = ffha_pkg::OP_RD;
      ffha_pkg::S_A_CHK: begin
        if (sts_i.fit) begin
          cmd_o.op = ffha_pkg::OP_CHK;
        end else if (!sts_i.last_alloc) begin
          cmd_o.op = ffha_pkg::OP_NEXT;
        end
      end
      ffha_pkg::S_A_SH: cmd_o.op = sts_i.sh_more ? ffha_pkg::OP_RD_PM1 : ffha_pkg::OP_WR_REM;
      ffha_pkg::S_A_SHWR: cmd_o.op = ffha_pkg::OP_WR_SHUP;
      ffha_pkg::S_A_WRU: cmd_o.op = ffha_pkg::OP_WR_USED;
      ffha_pkg::S_F_RD: cmd_o.op = ffha_pkg::OP_RD;
      ffha_pkg::S_F_CHK: begin
        if (sts_i.match) begin
          cmd_o.op = ffha_pkg::OP_CHK;
        end else if (!sts_i.last_free) begin
          cmd_o.op = ffha_pkg::OP_NEXT;
        end
      end
      ffha_pkg::S_F_LRD: cmd_o.op = ffha_pkg::OP_RD_M1;
      ffha_pkg::S_F_LCHK: begin
        if (sts_i.nbr_free) begin
          cmd_o.op = ffha_pkg::OP_MERGE_LO;
        end
      end
      ffha_pkg::S_F_URD: begin
        if (sts_i.has_upper) begin
          cmd_o.op = ffha_pkg::OP_RD_P1;
        end
      end
      ffha_pkg::S_F_UCHK: begin
        if (sts_i.nbr_free) begin
          cmd_o.op = ffha_pkg::OP_MERGE_HI;
        end
      end
      ffha_pkg::S_RM: cmd_o.op = sts_i.rm_more ? ffha_pkg::OP_RD_PP1 : ffha_pkg::OP_CNT_DEC;
      ffha_pkg::S_RM_WR: cmd_o.op = ffha_pkg::OP_WR_SHDN;
      ffha_pkg::S_F_WR: cmd_o.op = ffha_pkg::OP_WR_FREE;
      ffha_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = ffha_pkg::OP_PUSH;
        end
      end
      default: cmd_o.op = ffha_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_dp.sv =====
`default_nettype none

module ffha_dp #(
  parameter int unsigned ARENA_BITS = ffha_pkg::ARENA_BITS_DEF,
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [ARENA_BITS:0]   cfg_wdata_i,
  input  wire ffha_pkg::cmd_t        cmd_i,
  input  wire logic                  action_i,
  input  wire logic [ARENA_BITS:0]   request_bytes_i,
  input  wire logic [ARENA_BITS-1:0] release_offset_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [ARENA_BITS-1:0]      granted_offset_o,
  output ffha_pkg::sts_t             sts_o
);

  localparam int unsigned AW    = ARENA_BITS;
  localparam int unsigned LW    = ARENA_BITS + 1;        // block length
  localparam int unsigned NW    = ARENA_BITS + 2;        // rounded request
  localparam int unsigned XW    = ARENA_BITS + 3;        // need + split margin
  localparam int unsigned WW    = 2 * ARENA_BITS + 2;    // table word
  localparam int unsigned IW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW-1:0] ARENA_MAX = LW'(1) << AW;
  localparam logic [LW-1:0] ARENA_RST = (AW >= 20) ? (LW'(1) << 20) : ARENA_MAX;

  // Table word: {used, length, start}
  logic [WW-1:0] rdata;
  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic          rd_used;
  assign rd_start = rdata[AW-1:0];
  assign rd_len   = rdata[AW+LW-1:AW];
  assign rd_used  = rdata[WW-1];

  logic [LW-1:0] arena_q;
  logic          init_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx_q, ptr_q;
  logic [NW-1:0] need_q;
  logic [AW-1:0] off_q;
  logic          split_q;
  logic [AW-1:0] cur_start_q;
  logic [LW-1:0] cur_len_q;
  logic [1:0]    res_status_q;
  logic [AW-1:0] res_grant_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [AW-1:0] out_grant_q;

  // Request rounding: up to the 32-byte grain, zero counts as one grain
  logic [XW-1:0] req_round;
  logic [NW-1:0] need_new;
  assign req_round = (XW'(request_bytes_i) + XW'(ffha_pkg::ALIGN_MASK))
                     & ~XW'(ffha_pkg::ALIGN_MASK);
  assign need_new  = (req_round == '0) ? NW'(ffha_pkg::ALIGN_MASK + 1) : NW'(req_round);

  logic [CW-1:0] idx_ext, ptr_ext;
  assign idx_ext = CW'(idx_q);
  assign ptr_ext = CW'(ptr_q);

  logic split_now;
  assign split_now = (XW'(rd_len) >= XW'(need_q) + XW'(ffha_pkg::SPLIT_MIN))
                     && (cnt_q < CW'(MAX_BLOCKS));

  logic [AW-1:0] rd_grant;
  assign rd_grant = rd_start + AW'(ffha_pkg::HDR_BYTES);

  always_comb begin
    sts_o.init_pend  = init_q;
    sts_o.is_free    = action_i;
    sts_o.off_null   = (release_offset_i == '0);
    sts_o.fit        = !rd_used && (NW'(rd_len) >= need_q);
    sts_o.split      = split_now;
    sts_o.last_alloc = (idx_q == '0);
    sts_o.match      = (rd_grant == off_q);
    sts_o.last_free  = (idx_ext + CW'(1) == cnt_q);
    sts_o.idx_nz     = (idx_q != '0);
    sts_o.has_upper  = (idx_ext + CW'(1) < cnt_q);
    sts_o.nbr_free   = !rd_used;
    sts_o.sh_more    = (ptr_ext > idx_ext + CW'(1));
    sts_o.rm_more    = (ptr_ext + CW'(1) < cnt_q);
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Table port control
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [WW-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rdata;
    raddr = idx_q;
    case (cmd_i.op)
      ffha_pkg::OP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b0, arena_q, AW'(0)};
      end
      ffha_pkg::OP_RD_M1:  raddr = idx_q - IW'(1);
      ffha_pkg::OP_RD_P1:  raddr = idx_q + IW'(1);
      ffha_pkg::OP_RD_PM1: raddr = ptr_q - IW'(1);
      ffha_pkg::OP_RD_PP1: raddr = ptr_q + IW'(1);
      ffha_pkg::OP_WR_SHUP, ffha_pkg::OP_WR_SHDN: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata;
      end
      ffha_pkg::OP_WR_REM: begin
        we    = 1'b1;
        waddr = idx_q + IW'(1);
        wdata = {1'b0, cur_len_q - LW'(need_q), cur_start_q + AW'(need_q)};
      end
      ffha_pkg::OP_WR_USED: begin
        we    = 1'b1;
        wdata = {1'b1, split_q ? LW'(need_q) : cur_len_q, cur_start_q};
      end
      ffha_pkg::OP_WR_FREE: begin
        we    = 1'b1;
        wdata = {1'b0, cur_len_q, cur_start_q};
      end
      default: we = 1'b0;
    endcase
  end

  ffha_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q     <= ARENA_RST;
      init_q      <= 1'b1;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= (cfg_wdata_i > ARENA_MAX) ? ARENA_MAX : cfg_wdata_i;
        init_q  <= 1'b1;
      end else if (cmd_i.op == ffha_pkg::OP_INIT) begin
        init_q <= 1'b0;
      end
      case (cmd_i.op)
        ffha_pkg::OP_INIT:    cnt_q <= CW'(1);
        ffha_pkg::OP_WR_REM:  cnt_q <= cnt_q + CW'(1);
        ffha_pkg::OP_CNT_DEC: cnt_q <= cnt_q - CW'(1);
        default:              cnt_q <= cnt_q;
      endcase
      if (cmd_i.op == ffha_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ffha_pkg::OP_LOAD: begin
        need_q       <= need_new;
        off_q        <= release_offset_i;
        idx_q        <= (!action_i && cnt_q > CW'(1)) ? IW'(1) : '0;
        res_status_q <= action_i ? ffha_pkg::STS_IGNORED : ffha_pkg::STS_NO_FIT;
        res_grant_q  <= '0;
      end
      ffha_pkg::OP_CHK: begin
        cur_start_q <= rd_start;
        cur_len_q   <= rd_len;
        split_q     <= split_now;
        ptr_q       <= IW'(cnt_q);
      end
      ffha_pkg::OP_NEXT: begin
        idx_q <= (idx_ext + CW'(1) == cnt_q) ? '0 : idx_q + IW'(1);
      end
      ffha_pkg::OP_WR_SHUP: ptr_q <= ptr_q - IW'(1);
      ffha_pkg::OP_WR_SHDN: ptr_q <= ptr_q + IW'(1);
      ffha_pkg::OP_WR_USED: begin
        res_status_q <= ffha_pkg::STS_DONE;
        res_grant_q  <= cur_start_q + AW'(ffha_pkg::HDR_BYTES);
      end
      ffha_pkg::OP_MERGE_LO: begin
        cur_start_q <= rd_start;
        cur_len_q   <= cur_len_q + rd_len;
        ptr_q       <= idx_q;
        idx_q       <= idx_q - IW'(1);
      end
      ffha_pkg::OP_MERGE_HI: begin
        cur_len_q <= cur_len_q + rd_len;
        ptr_q     <= idx_q + IW'(1);
      end
      ffha_pkg::OP_WR_FREE: begin
        res_status_q <= ffha_pkg::STS_DONE;
        res_grant_q  <= '0;
      end
      ffha_pkg::OP_PUSH: begin
        out_status_q <= res_status_q;
        out_grant_q  <= res_grant_q;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_grant_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ffha_pkg::OP_PUSH) |-> !(out_valid_q && !out_ready_i))
    else $error("result pushed over an untaken result");

  a_used_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ffha_pkg::OP_WR_USED) |-> (NW'(cur_len_q) >= need_q))
    else $error("granted block shorter than request");

  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ffha_pkg::OP_WR_REM) |-> (cnt_q < CW'(MAX_BLOCKS)))
    else $error("split with a full table");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator. The arena is kept as an address-ordered table of
// blocks (start, length, used) in a single-port-write, single-port-read RAM of
// MAX_BLOCKS words. An allocate item rounds its size up to a multiple of 32
// bytes (zero counts as 32), searches blocks 1..count-1 and then block 0, takes
// the first free block that fits and splits it when at least 33 bytes would
// remain and the table has a spare slot; the grant is block start + 16. A free
// item looks up the block whose start + 16 equals the offset, merges it with a
// free lower and a free upper neighbor and marks it free; null or unknown
// offsets return status 2. Items are processed one at a time. A search reads
// the blocks one by one, each read followed by a check, and a split or a merge
// moves table entries one by one, each read from the RAM and then written back.
// The next item is accepted as soon as the previous result sits in the output
// register. After reset and after each arena size write the block rewrites
// table entry 0 before it takes an item.
`default_nettype none

module first_fit_heap_allocator_unit #(
  parameter int unsigned ARENA_BITS = ffha_pkg::ARENA_BITS_DEF,
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ARENA_BITS:0] cfg_wdata_i,
  ffha_req_if.sink                 req_i,
  ffha_rsp_if.source               rsp_o
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  // Sequencer: walks search, shift and merge steps
  ffha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Block table, index/count registers and output register
  ffha_dp #(
    .ARENA_BITS(ARENA_BITS),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .action_i        (req_i.action),
    .request_bytes_i (req_i.request_bytes),
    .release_offset_i(req_i.release_offset),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .granted_offset_o(rsp_o.granted_offset),
    .sts_o           (sts)
  );

  assign req_i.ready = cmd.in_ready;

endmodule

`default_nettype wire
